/* hdl/fsn_pkg.sv */
package fsn_pkg;

    localparam int NameLen = 11;
    localparam int BaseLen = 8;
    localparam int ExtLen  = 3;
    localparam int IdxW    = 4;

    localparam logic [7:0] SpaceByte = 8'h20;
    localparam logic [7:0] DotByte   = 8'h2e;
    localparam logic [7:0] LowerA    = 8'h61;
    localparam logic [7:0] LowerZ    = 8'h7a;
    localparam logic [7:0] CaseDiff  = 8'd32;

    localparam logic [IdxW-1:0] LastIdx = IdxW'(NameLen - 1);

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic                    valid;
        logic                    name_ok;
        logic [NameLen-1:0][7:0] bytes;
    } t_name_load;

    function automatic logic legal_char(input t_byte ch);
        logic ok;
        ok = 1'b1;
        if (ch < SpaceByte) begin
            ok = 1'b0;
        end
        case (ch)
            8'h22, 8'h2a, 8'h2b, 8'h2c, 8'h2f,
            8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e,
            8'h3f, 8'h5b, 8'h5c, 8'h5d, 8'h7c: ok = 1'b0;
            default: ;
        endcase
        return ok;
    endfunction

    function automatic t_byte upper_of(input t_byte ch);
        t_byte res;
        res = ch;
        if (ch >= LowerA && ch <= LowerZ) begin
            res = ch - CaseDiff;
        end
        return res;
    endfunction

endpackage

/* hdl/fsn_if.sv */
interface fsn_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface fsn_name_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic [3:0] byte_index;
    logic       name_valid;
    logic       last_byte;

    modport source (output valid, output name_byte, output byte_index,
                    output name_valid, output last_byte, input ready);
    modport sink   (input valid, input name_byte, input byte_index,
                    input name_valid, input last_byte, output ready);
endinterface

/* hdl/fsn_build.sv */
module fsn_build (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_char_code,
    input  logic                i_last_char,
    output fsn_pkg::t_name_load o_load
);

    logic       r_in_ext;
    logic [3:0] r_base_cnt;
    logic [1:0] r_ext_cnt;
    logic       r_bad;
    logic       r_first;
    logic [7:0] r_store [fsn_pkg::NameLen];

    logic       n_in_ext;
    logic [3:0] n_base_cnt;
    logic [1:0] n_ext_cnt;
    logic       n_bad;
    logic       n_first;
    logic [7:0] n_store [fsn_pkg::NameLen];

    logic       split;
    logic [7:0] up_char;

    assign split   = (i_char_code == fsn_pkg::DotByte) && r_first && !r_in_ext;
    assign up_char = fsn_pkg::upper_of(i_char_code);

    always_comb begin
        n_in_ext   = r_in_ext;
        n_base_cnt = r_base_cnt;
        n_ext_cnt  = r_ext_cnt;
        n_bad      = r_bad;
        n_first    = r_first;
        n_store    = r_store;
        o_load     = '0;
        if (i_take) begin
            if (split) begin
                n_in_ext = 1'b1;
            end else begin
                if (!fsn_pkg::legal_char(i_char_code)) begin
                    n_bad = 1'b1;
                end
                if (r_in_ext) begin
                    if (r_ext_cnt < 2'(fsn_pkg::ExtLen)) begin
                        n_store[4'(fsn_pkg::BaseLen) + 4'(r_ext_cnt)] = up_char;
                        n_ext_cnt = r_ext_cnt + 2'd1;
                    end
                end else if (r_base_cnt < 4'(fsn_pkg::BaseLen)) begin
                    n_store[r_base_cnt] = up_char;
                    n_base_cnt = r_base_cnt + 4'd1;
                end
            end
            n_first = 1'b1;
            if (i_last_char) begin
                o_load.valid   = 1'b1;
                o_load.name_ok = !n_bad;
                for (int k = 0; k < fsn_pkg::NameLen; k++) begin
                    o_load.bytes[k] = n_bad ? fsn_pkg::SpaceByte : n_store[k];
                end
                n_in_ext   = 1'b0;
                n_base_cnt = '0;
                n_ext_cnt  = '0;
                n_bad      = 1'b0;
                n_first    = 1'b0;
                for (int k = 0; k < fsn_pkg::NameLen; k++) begin
                    n_store[k] = fsn_pkg::SpaceByte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ext   <= 1'b0;
            r_base_cnt <= '0;
            r_ext_cnt  <= '0;
            r_bad      <= 1'b0;
            r_first    <= 1'b0;
            for (int k = 0; k < fsn_pkg::NameLen; k++) begin
                r_store[k] <= fsn_pkg::SpaceByte;
            end
        end else begin
            r_in_ext   <= n_in_ext;
            r_base_cnt <= n_base_cnt;
            r_ext_cnt  <= n_ext_cnt;
            r_bad      <= n_bad;
            r_first    <= n_first;
            r_store    <= n_store;
        end
    end

endmodule

/* hdl/fsn_emit.sv */
module fsn_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fsn_pkg::t_name_load i_load,
    output logic                o_can_load,
    fsn_name_if.source          o_name
);

    logic                               r_busy;
    logic [fsn_pkg::IdxW-1:0]           r_idx;
    logic                               r_ok;
    logic [fsn_pkg::NameLen-1:0][7:0]   r_buf;

    logic at_end;
    logic step;

    assign at_end     = (r_idx == fsn_pkg::LastIdx);
    assign step       = r_busy && o_name.ready;
    assign o_can_load = !r_busy || (step && at_end);

    assign o_name.valid      = r_busy;
    assign o_name.name_byte  = r_buf[r_idx];
    assign o_name.byte_index = r_idx;
    assign o_name.name_valid = r_ok;
    assign o_name.last_byte  = at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load.valid) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (step) begin
            if (at_end) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + fsn_pkg::IdxW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.valid) begin
            r_buf <= i_load.bytes;
            r_ok  <= i_load.name_ok;
        end
    end

endmodule

/* hdl/fat_short_name_formatter_top.sv */
// channel   dir  payload                                       transaction
// i_char    in   char_code[7:0], last_char                     one path character
// o_name    out  name_byte[7:0], byte_index[3:0], name_valid,  one byte of the 8.3 name
//                last_byte
// one character per cycle; the character state sits in registers and a result
// run of 11 bytes is copied to an output buffer when the last character is taken
// the buffer sends one byte per cycle while o_name is ready
// characters keep flowing while a run drains; only a last character stalls until
// the buffer is free, which is once the last byte of the previous run is sent
// synchronous active-low reset clears the character state and empties the buffer
module fat_short_name_formatter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fsn_char_if.sink   i_char,
    fsn_name_if.source o_name
);

    fsn_pkg::t_name_load load;
    logic                can_load;
    logic                take;

    assign i_char.ready = can_load || !i_char.last_char;
    assign take         = i_char.valid && i_char.ready;

    fsn_build u_build (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char_code (i_char.char_code),
        .i_last_char (i_char.last_char),
        .o_load      (load)
    );

    fsn_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .o_can_load (can_load),
        .o_name     (o_name)
    );

`ifndef SYNTHESIS
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_char.last_char |=> o_name.valid && o_name.byte_index == 4'd0)
        else $error("name run did not start after last character");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_name.valid && o_name.ready && !o_name.last_byte
        |=> o_name.valid && o_name.byte_index == $past(o_name.byte_index) + 4'd1)
        else $error("name run broken before last byte");

    a_invalid_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_name.valid && !o_name.name_valid |-> o_name.name_byte == fsn_pkg::SpaceByte)
        else $error("invalid name carries a non-space byte");
`endif

endmodule

/* test/fat_short_name_formatter_top_test.sv */
module fat_short_name_formatter_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        fsn_pkg::t_byte code;
        logic           fin;
        int             pre_gap;
    } t_path_char;

    typedef struct {
        fsn_pkg::t_byte           name_byte;
        logic [fsn_pkg::IdxW-1:0] byte_index;
        logic                     name_valid;
        logic                     last_byte;
    } t_name_beat;

    // characters that make a short name illegal, besides control codes
    localparam fsn_pkg::t_byte BadChars [15] = '{
        8'h22, 8'h2a, 8'h2b, 8'h2c, 8'h2f, 8'h3a, 8'h3b, 8'h3c,
        8'h3d, 8'h3e, 8'h3f, 8'h5b, 8'h5c, 8'h5d, 8'h7c
    };
    localparam int TailLen = 40;
    localparam int HoldCycles = 300;

    logic clk;
    logic rst_n;

    fsn_char_if char_bus ();
    fsn_name_if name_bus ();

    fat_short_name_formatter_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_char  (char_bus),
        .o_name  (name_bus)
    );

    t_path_char pending_q [$];
    t_name_beat expected_beats [$];

    logic           ext_mode;
    int             base_n;
    int             ext_n;
    logic           illegal_seen;
    logic           started;
    fsn_pkg::t_byte shadow_name [fsn_pkg::NameLen];

    int         accepted_chars;
    int         total_items;
    int         names_done;
    int         names_bad;
    int         bytes_checked;
    int         error_count;
    logic       hold_off;
    t_path_char staged_item;
    logic       staged;
    int         gap_left;
    int         stall_left;
    int         calm_left;
    t_name_beat want;

    always #6 clk = ~clk;

    function automatic logic char_is_legal(input fsn_pkg::t_byte c);
        if (c < fsn_pkg::SpaceByte) begin
            return 1'b0;
        end
        foreach (BadChars[i]) begin
            if (c == BadChars[i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic fsn_pkg::t_byte to_upper(input fsn_pkg::t_byte c);
        if (c >= fsn_pkg::LowerA && c <= fsn_pkg::LowerZ) begin
            return c - fsn_pkg::CaseDiff;
        end
        return c;
    endfunction

    function void clear_name_state();
        ext_mode = 1'b0;
        base_n = 0;
        ext_n = 0;
        illegal_seen = 1'b0;
        started = 1'b0;
        foreach (shadow_name[i]) begin
            shadow_name[i] = fsn_pkg::SpaceByte;
        end
    endfunction

    function void predict_name(input fsn_pkg::t_byte code, input logic fin);
        t_name_beat beat;
        if (code == fsn_pkg::DotByte && started && !ext_mode) begin
            ext_mode = 1'b1;
        end else begin
            if (!char_is_legal(code)) begin
                illegal_seen = 1'b1;
            end
            if (ext_mode) begin
                if (ext_n < fsn_pkg::ExtLen) begin
                    shadow_name[fsn_pkg::BaseLen + ext_n] = to_upper(code);
                    ext_n++;
                end
            end else if (base_n < fsn_pkg::BaseLen) begin
                shadow_name[base_n] = to_upper(code);
                base_n++;
            end
        end
        started = 1'b1;
        if (fin) begin
            for (int k = 0; k < fsn_pkg::NameLen; k++) begin
                beat.name_byte  = illegal_seen ? fsn_pkg::SpaceByte : shadow_name[k];
                beat.byte_index = fsn_pkg::IdxW'(k);
                beat.name_valid = !illegal_seen;
                beat.last_byte  = (fsn_pkg::IdxW'(k) == fsn_pkg::LastIdx);
                expected_beats.push_back(beat);
            end
            names_done++;
            if (illegal_seen) begin
                names_bad++;
            end
            clear_name_state();
        end
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    task automatic push_char(input fsn_pkg::t_byte code, input logic fin, input int gap);
        t_path_char item;
        item.code = code;
        item.fin = fin;
        item.pre_gap = gap;
        pending_q.push_back(item);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], i == s.len() - 1, 0);
        end
    endtask

    function automatic fsn_pkg::t_byte rand_plain_char();
        fsn_pkg::t_byte c;
        case ($urandom_range(0, 4))
            0: c = fsn_pkg::LowerA + fsn_pkg::t_byte'($urandom_range(0, 25));
            1: c = 8'h41 + fsn_pkg::t_byte'($urandom_range(0, 25));
            2: c = 8'h30 + fsn_pkg::t_byte'($urandom_range(0, 9));
            3: c = 8'h80 + fsn_pkg::t_byte'($urandom_range(0, 127));
            default: begin
                do begin
                    c = fsn_pkg::t_byte'($urandom_range(32, 127));
                end while (!char_is_legal(c) || c == fsn_pkg::DotByte);
            end
        endcase
        return c;
    endfunction

    function automatic fsn_pkg::t_byte rand_bad_char();
        if ($urandom_range(0, 1) == 0) begin
            return fsn_pkg::t_byte'($urandom_range(0, 31));
        end
        return BadChars[$urandom_range(0, 14)];
    endfunction

    task automatic gen_random_name();
        fsn_pkg::t_byte chars [$];
        int             kind;
        int             base_len;
        int             ext_len;
        int             gap_mode;
        int             gap;
        kind = $urandom_range(0, 9);
        gap_mode = $urandom_range(0, 2);
        if (kind == 0) begin
            repeat ($urandom_range(1, 14)) begin
                chars.push_back(fsn_pkg::t_byte'($urandom_range(0, 255)));
            end
        end else begin
            base_len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 6);
            ext_len = $urandom_range(0, 4);
            if ($urandom_range(0, 7) == 0) begin
                chars.push_back(fsn_pkg::DotByte);
            end
            repeat (base_len) begin
                chars.push_back(rand_plain_char());
            end
            if (ext_len != 0 || $urandom_range(0, 3) == 0) begin
                chars.push_back(fsn_pkg::DotByte);
            end
            repeat (ext_len) begin
                chars.push_back(($urandom_range(0, 7) == 0) ? fsn_pkg::DotByte
                                                            : rand_plain_char());
            end
            if (kind == 1) begin
                chars.insert($urandom_range(0, chars.size()), rand_bad_char());
            end
        end
        foreach (chars[i]) begin
            gap = (gap_mode != 0 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
            push_char(chars[i], i == chars.size() - 1, gap);
        end
    endtask

    // source side
    always @(posedge clk) begin
        if (!rst_n) begin
            char_bus.valid <= 1'b0;
            staged = 1'b0;
            gap_left = 0;
        end else begin
            if (char_bus.valid && char_bus.ready) begin
                predict_name(char_bus.char_code, char_bus.last_char);
                accepted_chars++;
            end
            if (!(char_bus.valid && !char_bus.ready)) begin
                if (!staged && pending_q.size() > 0) begin
                    staged_item = pending_q.pop_front();
                    gap_left = staged_item.pre_gap;
                    staged = 1'b1;
                end
                if (staged && gap_left == 0) begin
                    char_bus.valid <= 1'b1;
                    char_bus.char_code <= staged_item.code;
                    char_bus.last_char <= staged_item.fin;
                    staged = 1'b0;
                end else begin
                    char_bus.valid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                end
            end
        end
    end

    // sink side
    always @(posedge clk) begin
        if (!rst_n) begin
            name_bus.ready <= 1'b0;
            stall_left = 0;
            calm_left = 0;
        end else if (hold_off) begin
            name_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            name_bus.ready <= 1'b0;
            stall_left--;
            if (stall_left == 0 && $urandom_range(0, 2) == 0) begin
                calm_left = $urandom_range(20, 80);
            end
        end else if (calm_left > 0) begin
            name_bus.ready <= 1'b1;
            calm_left--;
        end else if (pending_q.size() >= TailLen && $urandom_range(0, 5) == 0) begin
            name_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 14);
        end else begin
            name_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && name_bus.valid && name_bus.ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("name byte %0d with nothing expected",
                                          name_bus.byte_index));
            end else begin
                want = expected_beats.pop_front();
                bytes_checked++;
                if (name_bus.name_byte !== want.name_byte) begin
                    report_mismatch($sformatf("index %0d name_byte %h, want %h",
                                              want.byte_index, name_bus.name_byte,
                                              want.name_byte));
                end
                if (name_bus.byte_index !== want.byte_index) begin
                    report_mismatch($sformatf("byte_index %0d, want %0d",
                                              name_bus.byte_index, want.byte_index));
                end
                if (name_bus.name_valid !== want.name_valid) begin
                    report_mismatch($sformatf("index %0d name_valid %b, want %b",
                                              want.byte_index, name_bus.name_valid,
                                              want.name_valid));
                end
                if (name_bus.last_byte !== want.last_byte) begin
                    report_mismatch($sformatf("index %0d last_byte %b, want %b",
                                              want.byte_index, name_bus.last_byte,
                                              want.last_byte));
                end
            end
        end
    end

    // long output stall while characters keep coming
    initial begin
        hold_off = 1'b0;
        wait (accepted_chars >= 60);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        char_bus.valid = 1'b0;
        char_bus.char_code = '0;
        char_bus.last_char = 1'b0;
        name_bus.ready = 1'b0;
        accepted_chars = 0;
        names_done = 0;
        names_bad = 0;
        bytes_checked = 0;
        error_count = 0;
        clear_name_state();

        push_char(8'h00, 1'b1, 0);
        push_text(".a");
        push_text("z.b.c");
        push_text("a.");
        push_char(8'hff, 1'b0, 0);
        push_char(8'h80, 1'b0, 0);
        push_text("{1234567.abcd");
        push_text("|");
        while (pending_q.size() < 160) begin
            gen_random_name();
        end
        for (int i = pending_q.size() - TailLen; i < pending_q.size(); i++) begin
            pending_q[i].pre_gap = 0;
        end
        total_items = pending_q.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_chars < total_items) @(posedge clk);
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);

        $display("%0d path characters sent, %0d names formatted (%0d invalid)",
                 accepted_chars, names_done, names_bad);
        $display("%0d name bytes checked, %0d mismatches", bytes_checked, error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/fsn_pkg.sv
hdl/fsn_if.sv
hdl/fsn_build.sv
hdl/fsn_emit.sv
hdl/fat_short_name_formatter_top.sv
test/fat_short_name_formatter_top_test.sv
